[src/bzr_pkg.sv]
// Shared types and fixed-point constants for the Bezier ribbon evaluator.
// No dependencies; imported by the channel users, the normalizer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bzr_pkg;

  // Fixed-point formats
  localparam int PARAM_FRAC_BITS = 16;
  localparam int COORD_WIDTH     = 32;
  localparam int PARAM_W         = 17;
  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;

  // Normalizer datapath widths
  localparam int NORM_W  = 30;  // normalized magnitude, below 2^30
  localparam int SQ_W    = 61;  // squared length
  localparam int ROOT_W  = 31;  // floor square root
  localparam int TRIAL_W = 63;  // square root trial value
  localparam int QUOT_W  = 16;  // unit component quotient
  localparam int NUM_W   = 46;  // divider numerator

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CP0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CP1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CP2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CP3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd4;
  localparam logic [31:0] WIDTH_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [PARAM_W-1:0] param_u;
    logic [PARAM_W-1:0] param_v;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          wdata;
  } cfg_t;

endpackage

`default_nettype wire

[src/bzr_chan_if.sv]
// Valid/ready channel interface with source and sink modports.
// Payload type is a parameter; the payload structs come from bzr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bzr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/bezier_ribbon_evaluator_core.sv]
// Bezier ribbon evaluator: position, unit tangent and normal for each (u, v) transaction.
// Depends on bzr_pkg, bzr_chan_if and bzr_norm_pipe.
//
// One result per input transaction, in order. The pipeline accepts one transaction per
// cycle unless the output stalls. It has 10 stages of Bernstein weights, products,
// sums and tangent normalization shift, 31 stages of bit-serial square root, 16 stages
// of restoring division for the unit components, and the output register. A stall on
// the output holds the whole pipeline; in_chan.ready follows the output register.
// Configuration writes are always accepted and take effect at once; write them only
// while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module bezier_ribbon_evaluator_core (
  input  logic       clk,
  input  logic       rst_n,
  bzr_chan_if.sink   in_chan,
  bzr_chan_if.source out_chan,
  bzr_chan_if.sink   cfg_chan
);
  import bzr_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  typedef struct packed {
    pos_t pos;
    logic neg_y;
    logic neg_z;
    logic deg;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  function automatic logic [PARAM_W-1:0] urnd(input logic [33:0] x);
    logic [33:0] sum;
    sum = x + (34'(1) << (PARAM_FRAC_BITS - 1));
    return PARAM_W'(sum >> PARAM_FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat_coord(input logic signed [63:0] x);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (COORD_WIDTH - 1));
    if (x > hi) return 32'(hi);
    else if (x < lo) return 32'(lo);
    else return 32'(x);
  endfunction

  // Configuration registers
  logic [63:0] cp_r [4];
  logic [31:0] width_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r[0] <= '0;
      cp_r[1] <= '0;
      cp_r[2] <= '0;
      cp_r[3] <= '0;
      width_r <= WIDTH_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.index)
        REG_CP0:   cp_r[0] <= cfg_chan.data.wdata;
        REG_CP1:   cp_r[1] <= cfg_chan.data.wdata;
        REG_CP2:   cp_r[2] <= cfg_chan.data.wdata;
        REG_CP3:   cp_r[3] <= cfg_chan.data.wdata;
        REG_WIDTH: width_r <= cfg_chan.data.wdata[31:0];
        default:   ;
      endcase
    end
  end

  logic signed [31:0] py [4];
  logic signed [31:0] pz [4];
  logic signed [32:0] dpy [3];
  logic signed [32:0] dpz [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      py[i] = $signed(cp_r[i][63:32]);
      pz[i] = $signed(cp_r[i][31:0]);
    end
    for (int i = 0; i < 3; i++) begin
      dpy[i] = 33'(py[i+1]) - 33'(py[i]);
      dpz[i] = 33'(pz[i+1]) - 33'(pz[i]);
    end
  end

  // Global advance: the pipeline moves when the output register can take data
  logic        adv;
  logic [10:1] sv_r;
  logic        out_v_r;
  out_t        out_data_r;

  assign adv           = !out_v_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[9:1], in_chan.valid};
    end
  end

  // S1: clamp parameters, raw squares, width product
  logic [PARAM_W-1:0] u_c, t_c, s_c;
  logic signed [18:0] pu;

  assign u_c = (in_chan.data.param_u > PARAM_ONE) ? PARAM_ONE : in_chan.data.param_u;
  assign t_c = (in_chan.data.param_v > PARAM_ONE) ? PARAM_ONE : in_chan.data.param_v;
  assign s_c = PARAM_ONE - t_c;
  assign pu  = $signed({1'b0, u_c, 1'b0}) - $signed(19'({2'b0, PARAM_ONE}));

  logic [PARAM_W-1:0] s1_s_r, s1_t_r;
  logic [33:0]        s1_ss_r, s1_st_r, s1_tt_r;
  logic signed [51:0] s1_px_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_s_r  <= s_c;
      s1_t_r  <= t_c;
      s1_ss_r <= 34'(s_c) * 34'(s_c);
      s1_st_r <= 34'(s_c) * 34'(t_c);
      s1_tt_r <= 34'(t_c) * 34'(t_c);
      s1_px_r <= 52'($signed({1'b0, width_r})) * 52'(pu);
    end
  end

  // S2: round squares, finish x
  logic [PARAM_W-1:0] s2_s_r, s2_t_r, s2_s2_r, s2_st_r, s2_t2_r;
  logic signed [31:0] s2_px_r;
  logic signed [51:0] px_rnd_nxt;

  assign px_rnd_nxt = (s1_px_r + (52'sd1 <<< PARAM_FRAC_BITS)) >>> (PARAM_FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s_r  <= s1_s_r;
      s2_t_r  <= s1_t_r;
      s2_s2_r <= urnd(s1_ss_r);
      s2_st_r <= urnd(s1_st_r);
      s2_t2_r <= urnd(s1_tt_r);
      s2_px_r <= sat_coord(64'(px_rnd_nxt));
    end
  end

  // S3: weight products and derivative term products
  logic [33:0]        s3_ws_r [4];
  logic signed [50:0] s3_dy_r [3];
  logic signed [50:0] s3_dz_r [3];
  logic signed [31:0] s3_px_r;
  logic signed [17:0] dw [3];

  assign dw[0] = $signed({1'b0, s2_s2_r});
  assign dw[1] = $signed({1'b0, s2_st_r});
  assign dw[2] = $signed({1'b0, s2_t2_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ws_r[0] <= 34'(s2_s2_r) * 34'(s2_s_r);
      s3_ws_r[1] <= 34'(s2_s2_r) * 34'(s2_t_r);
      s3_ws_r[2] <= 34'(s2_t2_r) * 34'(s2_s_r);
      s3_ws_r[3] <= 34'(s2_t2_r) * 34'(s2_t_r);
      for (int i = 0; i < 3; i++) begin
        s3_dy_r[i] <= 51'(dw[i]) * 51'(dpy[i]);
        s3_dz_r[i] <= 51'(dw[i]) * 51'(dpz[i]);
      end
      s3_px_r <= s2_px_r;
    end
  end

  // S4: Bernstein weights, derivative sums
  logic [18:0]        s4_w_r [4];
  logic signed [53:0] s4_dy_r, s4_dz_r;
  logic signed [31:0] s4_px_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_w_r[0] <= 19'(urnd(s3_ws_r[0]));
      s4_w_r[1] <= 19'(urnd(s3_ws_r[1])) * 19'd3;
      s4_w_r[2] <= 19'(urnd(s3_ws_r[2])) * 19'd3;
      s4_w_r[3] <= 19'(urnd(s3_ws_r[3]));
      s4_dy_r   <= 54'(s3_dy_r[0]) + (54'(s3_dy_r[1]) <<< 1) + 54'(s3_dy_r[2]);
      s4_dz_r   <= 54'(s3_dz_r[0]) + (54'(s3_dz_r[1]) <<< 1) + 54'(s3_dz_r[2]);
      s4_px_r   <= s3_px_r;
    end
  end

  // S5: position products, derivative magnitudes
  logic signed [51:0] s5_py_r [4];
  logic signed [51:0] s5_pz_r [4];
  logic [53:0]        s5_my_r, s5_mz_r;
  logic               s5_negy_r, s5_negz_r, s5_deg_r;
  logic signed [31:0] s5_px_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s5_py_r[i] <= 52'($signed({1'b0, s4_w_r[i]})) * 52'(py[i]);
        s5_pz_r[i] <= 52'($signed({1'b0, s4_w_r[i]})) * 52'(pz[i]);
      end
      s5_my_r   <= s4_dy_r[53] ? 54'(-s4_dy_r) : 54'(s4_dy_r);
      s5_mz_r   <= s4_dz_r[53] ? 54'(-s4_dz_r) : 54'(s4_dz_r);
      s5_negy_r <= s4_dy_r[53];
      s5_negz_r <= s4_dz_r[53];
      s5_deg_r  <= (s4_dy_r == '0) && (s4_dz_r == '0);
      s5_px_r   <= s4_px_r;
    end
  end

  // S6: position sums, leading one per 16-bit chunk
  logic [63:0] mor;
  logic [3:0]  cpos_nxt [4];
  logic [3:0]  cnz_nxt;

  always_comb begin
    mor = {10'b0, s5_my_r | s5_mz_r};
    for (int c = 0; c < 4; c++) begin
      cpos_nxt[c] = '0;
      cnz_nxt[c]  = 1'b0;
      for (int b = 0; b < 16; b++) begin
        if (mor[c*16+b]) begin
          cpos_nxt[c] = 4'(b);
          cnz_nxt[c]  = 1'b1;
        end
      end
    end
  end

  logic signed [53:0] s6_ay_r, s6_az_r;
  logic [3:0]         s6_cpos_r [4];
  logic [3:0]         s6_cnz_r;
  logic [53:0]        s6_my_r, s6_mz_r;
  logic               s6_negy_r, s6_negz_r, s6_deg_r;
  logic signed [31:0] s6_px_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ay_r   <= 54'(s5_py_r[0]) + 54'(s5_py_r[1]) + 54'(s5_py_r[2]) + 54'(s5_py_r[3]);
      s6_az_r   <= 54'(s5_pz_r[0]) + 54'(s5_pz_r[1]) + 54'(s5_pz_r[2]) + 54'(s5_pz_r[3]);
      s6_cpos_r <= cpos_nxt;
      s6_cnz_r  <= cnz_nxt;
      s6_my_r   <= s5_my_r;
      s6_mz_r   <= s5_mz_r;
      s6_negy_r <= s5_negy_r;
      s6_negz_r <= s5_negz_r;
      s6_deg_r  <= s5_deg_r;
      s6_px_r   <= s5_px_r;
    end
  end

  // S7: round and saturate y/z, pick leading chunk
  logic [5:0]         lead_nxt;
  logic signed [53:0] ay_rnd, az_rnd;

  always_comb begin
    priority if (s6_cnz_r[3]) lead_nxt = {2'd3, s6_cpos_r[3]};
    else if (s6_cnz_r[2])     lead_nxt = {2'd2, s6_cpos_r[2]};
    else if (s6_cnz_r[1])     lead_nxt = {2'd1, s6_cpos_r[1]};
    else                      lead_nxt = {2'd0, s6_cpos_r[0]};
  end

  assign ay_rnd = (s6_ay_r + (54'sd1 <<< (PARAM_FRAC_BITS - 1))) >>> PARAM_FRAC_BITS;
  assign az_rnd = (s6_az_r + (54'sd1 <<< (PARAM_FRAC_BITS - 1))) >>> PARAM_FRAC_BITS;

  pos_t        s7_pos_r;
  logic [5:0]  s7_lead_r;
  logic [53:0] s7_my_r, s7_mz_r;
  logic        s7_negy_r, s7_negz_r, s7_deg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_pos_r.x <= s6_px_r;
      s7_pos_r.y <= sat_coord(64'(ay_rnd));
      s7_pos_r.z <= sat_coord(64'(az_rnd));
      s7_lead_r  <= lead_nxt;
      s7_my_r    <= s6_my_r;
      s7_mz_r    <= s6_mz_r;
      s7_negy_r  <= s6_negy_r;
      s7_negz_r  <= s6_negz_r;
      s7_deg_r   <= s6_deg_r;
    end
  end

  // S8: normalize so the larger magnitude lies in [2^29, 2^30)
  localparam logic [5:0] NORM_TOP = 6'(NORM_W - 1);
  logic [NORM_W-1:0] ny_nxt, nz_nxt;

  always_comb begin
    if (s7_lead_r >= NORM_TOP) begin
      ny_nxt = NORM_W'(s7_my_r >> (s7_lead_r - NORM_TOP));
      nz_nxt = NORM_W'(s7_mz_r >> (s7_lead_r - NORM_TOP));
    end else begin
      ny_nxt = NORM_W'(s7_my_r << (NORM_TOP - s7_lead_r));
      nz_nxt = NORM_W'(s7_mz_r << (NORM_TOP - s7_lead_r));
    end
  end

  side_t             s8_side_r;
  logic [NORM_W-1:0] s8_ny_r, s8_nz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_side_r <= '{pos: s7_pos_r, neg_y: s7_negy_r, neg_z: s7_negz_r, deg: s7_deg_r};
      s8_ny_r   <= ny_nxt;
      s8_nz_r   <= nz_nxt;
    end
  end

  // S9: squares
  side_t               s9_side_r;
  logic [NORM_W-1:0]   s9_ny_r, s9_nz_r;
  logic [2*NORM_W-1:0] s9_sqy_r, s9_sqz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_side_r <= s8_side_r;
      s9_ny_r   <= s8_ny_r;
      s9_nz_r   <= s8_nz_r;
      s9_sqy_r  <= (2*NORM_W)'(s8_ny_r) * (2*NORM_W)'(s8_ny_r);
      s9_sqz_r  <= (2*NORM_W)'(s8_nz_r) * (2*NORM_W)'(s8_nz_r);
    end
  end

  // S10: squared length
  side_t             s10_side_r;
  logic [NORM_W-1:0] s10_ny_r, s10_nz_r;
  logic [SQ_W-1:0]   s10_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_side_r <= s9_side_r;
      s10_ny_r   <= s9_ny_r;
      s10_nz_r   <= s9_nz_r;
      s10_sq_r   <= SQ_W'(s9_sqy_r) + SQ_W'(s9_sqz_r);
    end
  end

  // Square root and unit component division
  logic              nv;
  logic [QUOT_W-1:0] qy, qz;
  logic [SIDE_W-1:0] nside_bits;
  side_t             nside;

  bzr_norm_pipe #(.SIDE_W(SIDE_W)) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (sv_r[10]),
    .in_sq    (s10_sq_r),
    .in_ny    (s10_ny_r),
    .in_nz    (s10_nz_r),
    .in_side  (s10_side_r),
    .out_valid(nv),
    .out_qy   (qy),
    .out_qz   (qz),
    .out_side (nside_bits)
  );

  assign nside = side_t'(nside_bits);

  // Clamp, sign, degenerate masking into the output register
  localparam logic [QUOT_W-1:0] UNIT_MAX = 16'h7FFF;
  logic [QUOT_W-1:0]  magy, magz;
  logic signed [15:0] ty_nxt, tz_nxt;

  always_comb begin
    magy = (qy > UNIT_MAX) ? UNIT_MAX : qy;
    magz = (qz > UNIT_MAX) ? UNIT_MAX : qz;
    ty_nxt = nside.neg_y ? -$signed(magy) : $signed(magy);
    tz_nxt = nside.neg_z ? -$signed(magz) : $signed(magz);
    if (nside.deg) begin
      ty_nxt = '0;
      tz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.pos_x      <= nside.pos.x;
      out_data_r.pos_y      <= nside.pos.y;
      out_data_r.pos_z      <= nside.pos.z;
      out_data_r.tangent_y  <= ty_nxt;
      out_data_r.tangent_z  <= tz_nxt;
      out_data_r.normal_y   <= tz_nxt;
      out_data_r.normal_z   <= -ty_nxt;
      out_data_r.degenerate <= nside.deg;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_data_r;

`ifndef SYNTHESIS
  // Degenerate results carry a zero tangent
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_data_r.degenerate |->
      (out_data_r.tangent_y == '0) && (out_data_r.tangent_z == '0))
    else $error("degenerate result with nonzero tangent");

  // Normal is the tangent rotated a quarter turn about x
  a_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_data_r.normal_y == out_data_r.tangent_z) &&
                (out_data_r.normal_z == 16'(-out_data_r.tangent_y)))
    else $error("normal does not match tangent");

  // A held result survives a stall unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_chan.ready |=> out_v_r && $stable(out_data_r))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

[src/bzr_norm_pipe.sv]
// Pipelined floor square root and two unit-component dividers, one bit per stage.
// Depends on bzr_pkg for widths; side data rides along with each transaction.
`timescale 1ns / 1ps
`default_nettype none

module bzr_norm_pipe #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [bzr_pkg::SQ_W-1:0]   in_sq,
  input  logic [bzr_pkg::NORM_W-1:0] in_ny,
  input  logic [bzr_pkg::NORM_W-1:0] in_nz,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [bzr_pkg::QUOT_W-1:0] out_qy,
  output logic [bzr_pkg::QUOT_W-1:0] out_qz,
  output logic [SIDE_W-1:0]          out_side
);
  import bzr_pkg::*;

  // Square root stages
  logic              sq_v_r    [ROOT_W];
  logic [SQ_W-1:0]   sq_rem_r  [ROOT_W];
  logic [ROOT_W-1:0] sq_root_r [ROOT_W];
  logic [NORM_W-1:0] sq_ny_r   [ROOT_W];
  logic [NORM_W-1:0] sq_nz_r   [ROOT_W];
  logic [SIDE_W-1:0] sq_side_r [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic              pv;
    logic [SQ_W-1:0]   prem;
    logic [ROOT_W-1:0] proot;
    logic [NORM_W-1:0] pny, pnz;
    logic [SIDE_W-1:0] pside;
    logic [TRIAL_W-1:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_sq;
      assign proot = '0;
      assign pny   = in_ny;
      assign pnz   = in_nz;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = sq_v_r[k-1];
      assign prem  = sq_rem_r[k-1];
      assign proot = sq_root_r[k-1];
      assign pny   = sq_ny_r[k-1];
      assign pnz   = sq_nz_r[k-1];
      assign pside = sq_side_r[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (TRIAL_W'(proot) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
    assign take  = TRIAL_W'(prem) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]  <= take ? SQ_W'(TRIAL_W'(prem) - trial) : prem;
        sq_root_r[k] <= take ? (proot | (ROOT_W'(1) << B)) : proot;
        sq_ny_r[k]   <= pny;
        sq_nz_r[k]   <= pnz;
        sq_side_r[k] <= pside;
      end
    end
  end

  // Divider stages: q = (mag * 2^15 + r/2) / r, restoring, one quotient bit per stage
  logic              dv_v_r    [QUOT_W];
  logic [NUM_W-1:0]  dv_ry_r   [QUOT_W];
  logic [NUM_W-1:0]  dv_rz_r   [QUOT_W];
  logic [QUOT_W-1:0] dv_qy_r   [QUOT_W];
  logic [QUOT_W-1:0] dv_qz_r   [QUOT_W];
  logic [ROOT_W-1:0] dv_root_r [QUOT_W];
  logic [SIDE_W-1:0] dv_side_r [QUOT_W];

  genvar j;
  for (j = 0; j < QUOT_W; j++) begin : g_div
    localparam int B = QUOT_W - 1 - j;
    logic              pv;
    logic [NUM_W-1:0]  pry, prz;
    logic [QUOT_W-1:0] pqy, pqz;
    logic [ROOT_W-1:0] proot;
    logic [SIDE_W-1:0] pside;
    logic [NUM_W:0]    dvs;
    logic              take_y, take_z;

    if (j == 0) begin : g_first
      logic [ROOT_W-1:0] root;
      assign root  = sq_root_r[ROOT_W-1];
      assign pv    = sq_v_r[ROOT_W-1];
      assign pry   = (NUM_W'(sq_ny_r[ROOT_W-1]) << (QUOT_W - 1)) + NUM_W'(root >> 1);
      assign prz   = (NUM_W'(sq_nz_r[ROOT_W-1]) << (QUOT_W - 1)) + NUM_W'(root >> 1);
      assign pqy   = '0;
      assign pqz   = '0;
      assign proot = root;
      assign pside = sq_side_r[ROOT_W-1];
    end else begin : g_next
      assign pv    = dv_v_r[j-1];
      assign pry   = dv_ry_r[j-1];
      assign prz   = dv_rz_r[j-1];
      assign pqy   = dv_qy_r[j-1];
      assign pqz   = dv_qz_r[j-1];
      assign proot = dv_root_r[j-1];
      assign pside = dv_side_r[j-1];
    end

    assign dvs    = (NUM_W+1)'(proot) << B;
    assign take_y = {1'b0, pry} >= dvs;
    assign take_z = {1'b0, prz} >= dvs;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ry_r[j]   <= take_y ? NUM_W'({1'b0, pry} - dvs) : pry;
        dv_rz_r[j]   <= take_z ? NUM_W'({1'b0, prz} - dvs) : prz;
        dv_qy_r[j]   <= pqy | (take_y ? (QUOT_W'(1) << B) : '0);
        dv_qz_r[j]   <= pqz | (take_z ? (QUOT_W'(1) << B) : '0);
        dv_root_r[j] <= proot;
        dv_side_r[j] <= pside;
      end
    end
  end

  assign out_valid = dv_v_r[QUOT_W-1];
  assign out_qy    = dv_qy_r[QUOT_W-1];
  assign out_qz    = dv_qz_r[QUOT_W-1];
  assign out_side  = dv_side_r[QUOT_W-1];

endmodule

`default_nettype wire

[tb/tb_bezier_ribbon_evaluator_core.sv]
// Self-checking testbench for bezier_ribbon_evaluator_core: random and directed (u, v)
// transactions and control-point settings, checked against an in-bench pose predictor.
// Depends on bzr_pkg, bzr_chan_if and the evaluator RTL.
`timescale 1ns / 1ps

module tb_bezier_ribbon_evaluator_core;
  import bzr_pkg::*;

  localparam int          LATENCY   = 58;
  localparam longint      COORD_MAX = 64'sd2147483647;
  localparam longint      COORD_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Predicts one pose per (u, v) transaction and checks the returned poses in order
  class ribbon_pose_checker;
    bit [63:0] ctrl_pts[4];
    bit [31:0] rib_width;
    out_t      pending_poses[$];
    int        errors;

    function new();
      ctrl_pts  = '{default: 64'd0};
      rib_width = WIDTH_RESET;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_CP0, REG_CP1, REG_CP2, REG_CP3: ctrl_pts[idx] = val;
        REG_WIDTH: rib_width = val[31:0];
        default: ;  // unmapped index, ignored
      endcase
    endfunction

    // round to nearest, ties toward plus infinity
    function longint round_shift(longint x, int sh);
      return (x + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function bit [63:0] frac_round(bit [63:0] x);
      return (x + (64'd1 << (PARAM_FRAC_BITS - 1))) >> PARAM_FRAC_BITS;
    endfunction

    function longint clamp_coord(longint x);
      return x > COORD_MAX ? COORD_MAX : (x < COORD_MIN ? COORD_MIN : x);
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] n);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unit_part(bit [63:0] mag, bit neg, bit [63:0] r);
      bit [63:0] q;
      q = ((mag << 15) + (r >> 1)) / r;
      if (q > 64'd32767) q = 64'd32767;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function out_t predict_pose(in_t it);
      bit [63:0] u, t, s, s2, st, t2, my, mz, r, one;
      longint py[4], pz[4], w[4];
      longint ay, az, px, dy, dz, ty, tz, nz;
      out_t   o;
      one = PARAM_ONE;
      u = it.param_u;
      t = it.param_v;
      if (u > one) u = one;
      if (t > one) t = one;
      s = one - t;
      for (int i = 0; i < 4; i++) begin
        py[i] = $signed(ctrl_pts[i][63:32]);
        pz[i] = $signed(ctrl_pts[i][31:0]);
      end
      px = round_shift(longint'(rib_width) * (2 * longint'(u) - longint'(one)),
                       PARAM_FRAC_BITS + 1);
      s2 = frac_round(s * s);
      st = frac_round(s * t);
      t2 = frac_round(t * t);
      w[0] = longint'(frac_round(s2 * s));
      w[1] = 3 * longint'(frac_round(s2 * t));
      w[2] = 3 * longint'(frac_round(t2 * s));
      w[3] = longint'(frac_round(t2 * t));
      ay = 0;
      az = 0;
      for (int i = 0; i < 4; i++) begin
        ay += w[i] * py[i];
        az += w[i] * pz[i];
      end
      o.pos_x = clamp_coord(px);
      o.pos_y = clamp_coord(round_shift(ay, PARAM_FRAC_BITS));
      o.pos_z = clamp_coord(round_shift(az, PARAM_FRAC_BITS));
      // derivative direction, factor 3 dropped
      dy = longint'(s2) * (py[1] - py[0]) + 2 * longint'(st) * (py[2] - py[1])
         + longint'(t2) * (py[3] - py[2]);
      dz = longint'(s2) * (pz[1] - pz[0]) + 2 * longint'(st) * (pz[2] - pz[1])
         + longint'(t2) * (pz[3] - pz[2]);
      ty = 0;
      tz = 0;
      o.degenerate = 1'b0;
      if (dy == 0 && dz == 0) begin
        o.degenerate = 1'b1;
      end else begin
        my = dy < 0 ? -dy : dy;
        mz = dz < 0 ? -dz : dz;
        while ((my > mz ? my : mz) >= (64'd1 << 30)) begin
          my >>= 1;
          mz >>= 1;
        end
        while ((my > mz ? my : mz) < (64'd1 << 29)) begin
          my <<= 1;
          mz <<= 1;
        end
        r  = floor_sqrt(my * my + mz * mz);
        ty = unit_part(my, dy < 0, r);
        tz = unit_part(mz, dz < 0, r);
      end
      nz = -ty;
      o.tangent_y = ty[15:0];
      o.tangent_z = tz[15:0];
      o.normal_y  = tz[15:0];
      o.normal_z  = nz[15:0];
      return o;
    endfunction

    function void note_input(in_t it);
      pending_poses.push_back(predict_pose(it));
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, got %h", $time, got);
        return;
      end
      want = pending_poses.pop_front();
      check_field("pos_x", want.pos_x, got.pos_x);
      check_field("pos_y", want.pos_y, got.pos_y);
      check_field("pos_z", want.pos_z, got.pos_z);
      check_field("tangent_y", 32'(want.tangent_y), 32'(got.tangent_y));
      check_field("tangent_z", 32'(want.tangent_z), 32'(got.tangent_z));
      check_field("normal_y", 32'(want.normal_y), 32'(got.normal_y));
      check_field("normal_z", 32'(want.normal_z), 32'(got.normal_z));
      check_field("degenerate", 32'(want.degenerate), 32'(got.degenerate));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idling_on;

  bzr_chan_if #(.T(in_t))  in_if  ();
  bzr_chan_if #(.T(out_t)) out_if ();
  bzr_chan_if #(.T(cfg_t)) cfg_if ();

  ribbon_pose_checker pose_chk = new();

  bezier_ribbon_evaluator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #3000000;
    $display("** bezier_ribbon_evaluator_core: FAILED **");
    $finish;
  end

  // Result side: random stall bursts
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) pose_chk.check_result(out_if.data);
  end

  // One input transaction; valid stays high across back-to-back items
  task automatic send_point(input logic [16:0] u, input logic [16:0] v);
    in_t it;
    it.param_u = u;
    it.param_v = v;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    pose_chk.note_input(it);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    while (pose_chk.pending_poses.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_t c;
    c.index = idx;
    c.wdata = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk); while (!cfg_if.ready);
    pose_chk.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_curve(input logic [63:0] p0, input logic [63:0] p1,
                            input logic [63:0] p2, input logic [63:0] p3,
                            input logic [31:0] w);
    write_reg(REG_CP0, p0);
    write_reg(REG_CP1, p1);
    write_reg(REG_CP2, p2);
    write_reg(REG_CP3, p3);
    write_reg(REG_WIDTH, {32'd0, w});
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_point(int kind);
    logic [31:0] y, z;
    case (kind)
      0: begin
        y = $urandom();
        z = $urandom();
      end
      1: begin
        y = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      default: begin
        y = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        z = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      end
    endcase
    return {y, z};
  endfunction

  function automatic logic [16:0] rand_param();
    if ($urandom_range(0, 15) == 0) return 17'($urandom_range(0, 131071));
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? PARAM_ONE : 17'd0;
    return 17'($urandom_range(0, 65536));
  endfunction

  // Stimulus
  initial begin
    logic [63:0] p[4];
    logic [31:0] w;
    int kind;
    idling_on    = 1'b1;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: flat curve, every point degenerate
    send_point(17'd0, 17'd0);
    send_point(PARAM_ONE, PARAM_ONE);
    send_point(17'h1FFFF, 17'h1FFFF);
    send_point(17'd32768, 17'd65537);
    end_burst();

    // extreme control points and width, unmapped register write
    load_curve({32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
               {32'h7FFF_FFFF, 32'h8000_0000}, {32'h8000_0000, 32'h7FFF_FFFF},
               32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
    send_point(17'd0, 17'd0);
    send_point(PARAM_ONE, 17'd32768);
    send_point(17'h1FFFF, PARAM_ONE);
    send_point(17'd1, 17'd65535);
    send_point(17'd65535, 17'd1);
    end_burst();

    // ordinary S-curve; first two points equal, so v = 0 is degenerate
    load_curve({32'h0001_0000, 32'h0000_0000}, {32'h0001_0000, 32'h0000_0000},
               {32'hFFFE_0000, 32'h0003_0000}, {32'h0000_8000, 32'hFFFF_0000},
               32'h0000_0000);
    send_point(17'd32768, 17'd0);
    send_point(17'd0, 17'd16384);
    send_point(17'd65536, 17'd49152);
    send_point(17'd12345, PARAM_ONE);
    send_point(17'h10000, 17'h10000);
    send_point(17'd40000, 17'd32768);
    end_burst();

    // random phases; the last one runs with no idling
    for (int ph = 0; ph < 7; ph++) begin
      kind = ph % 3;
      for (int i = 0; i < 4; i++) p[i] = rand_point(kind);
      if (ph == 4) p[3] = p[2];  // degenerate at v = 1
      if (ph == 5) begin
        p[1] = p[0];
        p[2] = p[0];
        p[3] = p[0];
      end
      case (ph % 4)
        0: w = $urandom();
        1: w = 32'hFFFF_FFFF;
        2: w = 32'd0;
        default: w = $urandom_range(0, 32'h0010_0000);
      endcase
      if (ph == 6) idling_on = 1'b0;
      load_curve(p[0], p[1], p[2], p[3], w);
      for (int i = 0; i < 190; i++) begin
        send_point(rand_param(), rand_param());
        // let the pipeline drain completely once mid-stream
        if (ph == 1 && i == 95) begin
          in_if.valid <= 1'b0;
          while (pose_chk.pending_poses.size() != 0) @(negedge clk);
        end
      end
      end_burst();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (pose_chk.errors == 0 && pose_chk.pending_poses.size() == 0) begin
      $display("** bezier_ribbon_evaluator_core: PASSED **");
    end else begin
      $display("** bezier_ribbon_evaluator_core: FAILED **");
    end
    $finish;
  end

endmodule
